[hw/rtl/vccsu_pkg.sv]
// vccsu_pkg: shared types and constants for the vector compare, clip and select unit
// command codes, per-lane flag struct, flag vector and result beat types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vccsu_pkg;

	localparam int LANES  = 8;
	localparam int LANE_W = 16;
	localparam int HALF   = LANES / 2;
	localparam int WORD_W = HALF * LANE_W;

	typedef enum logic [2:0] {
		CMD_LT        = 3'd0,
		CMD_EQ        = 3'd1,
		CMD_NE        = 3'd2,
		CMD_GE        = 3'd3,
		CMD_CLIP_LOW  = 3'd4,
		CMD_CLIP_HIGH = 3'd5,
		CMD_CLIP_REV  = 3'd6,
		CMD_MERGE     = 3'd7
	} cmd_t;

	typedef struct packed {
		logic ne;
		logic co;
		logic comp;
		logic clip;
		logic vce;
	} lane_flags_t;

	typedef struct packed {
		logic [LANES-1:0] ne;
		logic [LANES-1:0] co;
		logic [LANES-1:0] comp;
		logic [LANES-1:0] clip;
		logic [LANES-1:0] vce;
	} flag_vec_t;

	typedef struct packed {
		logic [WORD_W-1:0] vd_low;
		logic [WORD_W-1:0] vd_high;
		flag_vec_t         flags;
	} out_beat_t;

endpackage

`default_nettype wire

[hw/rtl/vccsu_if.sv]
// vccsu_in_if / vccsu_out_if: valid-ready channels of the compare, clip and select unit
// operand beat in, result beat out; fixed field widths, no package needed
`timescale 1ns / 1ps
`default_nettype none

interface vccsu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [63:0] vs_low;
	logic [63:0] vs_high;
	logic [63:0] vt_low;
	logic [63:0] vt_high;

	modport source (output valid, command, vs_low, vs_high, vt_low, vt_high, input ready);
	modport sink   (input valid, command, vs_low, vs_high, vt_low, vt_high, output ready);
endinterface

interface vccsu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] vd_low;
	logic [63:0] vd_high;
	logic [7:0]  ne_flags;
	logic [7:0]  co_flags;
	logic [7:0]  comp_flags;
	logic [7:0]  clip_flags;
	logic [7:0]  vce_flags;

	modport source (output valid, vd_low, vd_high, ne_flags, co_flags, comp_flags,
		clip_flags, vce_flags, input ready);
	modport sink   (input valid, vd_low, vd_high, ne_flags, co_flags, comp_flags,
		clip_flags, vce_flags, output ready);
endinterface

`default_nettype wire

[hw/rtl/vccsu_lane.sv]
// vccsu_lane: one 16-bit lane of compare, clip and merge, purely combinational
// depends on vccsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module vccsu_lane (
	input  wire logic [2:0]                      command,
	input  wire logic [vccsu_pkg::LANE_W-1:0]    s,
	input  wire logic [vccsu_pkg::LANE_W-1:0]    t,
	input  wire vccsu_pkg::lane_flags_t          flags_old,
	output vccsu_pkg::lane_flags_t               flags_new,
	output logic [vccsu_pkg::LANE_W-1:0]         res
);
	import vccsu_pkg::*;

	logic signed [LANE_W-1:0] ss;
	logic signed [LANE_W-1:0] ts;
	logic signed [LANE_W-1:0] not_s;
	logic signed [LANE_W:0]   ssum;
	logic [LANE_W:0]          usum;
	logic [LANE_W-1:0]        neg_t;
	logic                     sn;
	logic                     t_neg;
	logic                     s_eq_t;
	logic                     s_lt_t;

	logic [LANE_W-1:0] vc_low;
	logic              lz;
	logic              uz;
	logic              len;
	logic              gen;
	logic              eqf;
	logic              le;
	logic              ge;
	logic              sel;
	logic              vce_h;

	assign ss     = $signed(s);
	assign ts     = $signed(t);
	assign not_s  = ~ss;
	assign ssum   = {ss[LANE_W-1], ss} + {ts[LANE_W-1], ts};
	assign usum   = {1'b0, s} + {1'b0, t};
	assign neg_t  = ~t + LANE_W'(1);
	assign sn     = s[LANE_W-1] ^ t[LANE_W-1];
	assign t_neg  = t[LANE_W-1];
	assign s_eq_t = (s == t);
	assign s_lt_t = (ss < ts);

	always_comb begin
		flags_new = flags_old;
		res       = s;
		vc_low    = flags_old.co ? neg_t : t;
		lz        = (s == vc_low);
		uz        = ~usum[LANE_W];
		len       = flags_old.vce ? (lz | uz) : (lz & uz);
		gen       = (s >= vc_low);
		eqf       = 1'b0;
		le        = 1'b0;
		ge        = 1'b0;
		sel       = 1'b0;
		vce_h     = sn & (ssum == -(LANE_W+1)'(1));
		case (cmd_t'(command))
			CMD_LT: begin
				flags_new.comp = s_lt_t | (s_eq_t & flags_old.ne & flags_old.co);
				res = flags_new.comp ? s : t;
				flags_new.clip = 1'b0;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
			end
			CMD_EQ: begin
				flags_new.comp = s_eq_t & ~flags_old.ne;
				res = t;
				flags_new.clip = 1'b0;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
			end
			CMD_NE: begin
				flags_new.comp = ~s_eq_t | flags_old.ne;
				res = s;
				flags_new.clip = 1'b0;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
			end
			CMD_GE: begin
				flags_new.comp = (~s_lt_t & ~s_eq_t) |
					(s_eq_t & ~(flags_old.ne & flags_old.co));
				res = flags_new.comp ? s : t;
				flags_new.clip = 1'b0;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
			end
			CMD_CLIP_LOW: begin
				eqf = ~flags_old.ne;
				le  = (eqf & flags_old.co) ? len : flags_old.comp;
				ge  = (eqf & ~flags_old.co) ? gen : flags_old.clip;
				sel = flags_old.co ? le : ge;
				res = sel ? vc_low : s;
				flags_new.clip = ge;
				flags_new.comp = le;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
				flags_new.vce  = 1'b0;
			end
			CMD_CLIP_HIGH: begin
				eqf = sn ? (ssum == '0) : s_eq_t;
				le  = sn ? (ssum[LANE_W] | (ssum == '0)) : t_neg;
				ge  = sn ? t_neg : ~s_lt_t;
				sel = sn ? le : ge;
				res = sel ? (sn ? neg_t : t) : s;
				flags_new.clip = ge;
				flags_new.comp = le;
				flags_new.vce  = vce_h;
				flags_new.ne   = ~(eqf | vce_h);
				flags_new.co   = sn;
			end
			CMD_CLIP_REV: begin
				le  = sn ? (ts <= not_s) : t_neg;
				ge  = sn ? t_neg : ~s_lt_t;
				sel = sn ? le : ge;
				res = sel ? (sn ? ~t : t) : s;
				flags_new.clip = ge;
				flags_new.comp = le;
				flags_new.ne   = 1'b0;
				flags_new.co   = 1'b0;
				flags_new.vce  = 1'b0;
			end
			CMD_MERGE: begin
				res = flags_old.comp ? s : t;
			end
			default: begin
				res = flags_old.comp ? s : t;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/vccsu_merge.sv]
// vccsu_merge: gathers the lane results, holds the flag state and the output beat
// output register plus one skid entry; depends on vccsu_pkg and vccsu_if
`timescale 1ns / 1ps
`default_nettype none

module vccsu_merge (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [vccsu_pkg::LANE_W-1:0]        lane_res [vccsu_pkg::LANES],
	input  wire vccsu_pkg::lane_flags_t              lane_flags [vccsu_pkg::LANES],
	output vccsu_pkg::flag_vec_t                     flags,
	output logic                                     in_ready,
	vccsu_out_if.source                              dout
);
	import vccsu_pkg::*;

	flag_vec_t flags_q;
	flag_vec_t flags_nxt;
	out_beat_t beat_nxt;
	out_beat_t out_q;
	out_beat_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      out_free;

	always_comb begin
		flags_nxt = flags_q;
		beat_nxt  = '0;
		for (int k = 0; k < LANES; k++) begin
			flags_nxt.ne[k]   = lane_flags[k].ne;
			flags_nxt.co[k]   = lane_flags[k].co;
			flags_nxt.comp[k] = lane_flags[k].comp;
			flags_nxt.clip[k] = lane_flags[k].clip;
			flags_nxt.vce[k]  = lane_flags[k].vce;
			if (k < HALF) begin
				beat_nxt.vd_low[k*LANE_W +: LANE_W] = lane_res[k];
			end else begin
				beat_nxt.vd_high[(k-HALF)*LANE_W +: LANE_W] = lane_res[k];
			end
		end
		beat_nxt.flags = flags_nxt;
	end

	assign out_free = ~out_valid_q | dout.ready;
	assign in_ready = ~skid_valid_q;
	assign flags    = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				flags_q <= flags_nxt;
			end
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= beat_nxt;
			end
		end else if (accept) begin
			skid_q <= beat_nxt;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.vd_low     = out_q.vd_low;
	assign dout.vd_high    = out_q.vd_high;
	assign dout.ne_flags   = out_q.flags.ne;
	assign dout.co_flags   = out_q.flags.co;
	assign dout.comp_flags = out_q.flags.comp;
	assign dout.clip_flags = out_q.flags.clip;
	assign dout.vce_flags  = out_q.flags.vce;

endmodule

`default_nettype wire

[hw/rtl/vector_compare_clip_select_unit_top.sv]
// vector_compare_clip_select_unit_top: eight-lane compare, clip and select unit
// instantiates vccsu_lane (x8) and vccsu_merge; depends on vccsu_pkg and vccsu_if
//
//   port  dir  handshake     payload
//   din   in   valid/ready   command, vs_low, vs_high, vt_low, vt_high
//   dout  out  valid/ready   vd_low, vd_high, ne/co/comp/clip/vce flags
//
// one beat per cycle while din.ready is high; a result is registered in the output stage
// the eight lanes work in parallel off the flag state, which updates on every accepted beat
// an output register plus one skid entry keep din open while dout stalls for one beat
// arst_n clears all flags to zero and empties the output stage
`timescale 1ns / 1ps
`default_nettype none

module vector_compare_clip_select_unit_top (
	input  wire logic clk,
	input  wire logic arst_n,
	vccsu_in_if.sink   din,
	vccsu_out_if.source dout
);
	import vccsu_pkg::*;

	logic                accept;
	logic                in_ready;
	flag_vec_t           flags;
	logic [LANE_W-1:0]   lane_s     [LANES];
	logic [LANE_W-1:0]   lane_t     [LANES];
	logic [LANE_W-1:0]   lane_res   [LANES];
	lane_flags_t         lane_old   [LANES];
	lane_flags_t         lane_new   [LANES];

	assign din.ready = in_ready;
	assign accept    = din.valid & in_ready;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		if (k < HALF) begin : g_lo
			assign lane_s[k] = din.vs_low[k*LANE_W +: LANE_W];
			assign lane_t[k] = din.vt_low[k*LANE_W +: LANE_W];
		end else begin : g_hi
			assign lane_s[k] = din.vs_high[(k-HALF)*LANE_W +: LANE_W];
			assign lane_t[k] = din.vt_high[(k-HALF)*LANE_W +: LANE_W];
		end

		assign lane_old[k].ne   = flags.ne[k];
		assign lane_old[k].co   = flags.co[k];
		assign lane_old[k].comp = flags.comp[k];
		assign lane_old[k].clip = flags.clip[k];
		assign lane_old[k].vce  = flags.vce[k];

		vccsu_lane u_lane (
			.command   (din.command),
			.s         (lane_s[k]),
			.t         (lane_t[k]),
			.flags_old (lane_old[k]),
			.flags_new (lane_new[k]),
			.res       (lane_res[k])
		);
	end

	vccsu_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.lane_res   (lane_res),
		.lane_flags (lane_new),
		.flags      (flags),
		.in_ready   (in_ready),
		.dout       (dout)
	);

	// a full skid entry means the output register is holding a beat too
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> dout.valid)
		else $error("skid full with empty output register");

	// a beat taken while the output stalls lands in the skid entry
	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dout.valid && !dout.ready |=> !in_ready)
		else $error("stalled beat not held in skid entry");

	// merge leaves every flag untouched
	a_merge_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (din.command == CMD_MERGE) |=> $stable(flags))
		else $error("merge changed the flag state");

	// clip low clears not-equal, carry and extension flags
	a_clip_low_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (din.command == CMD_CLIP_LOW) |=>
		(flags.ne == '0) && (flags.co == '0) && (flags.vce == '0))
		else $error("clip low left stale flags");

endmodule

`default_nettype wire
